// ===== rtl/sdspi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types and codes shared by the SD card SPI block transfer engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

   typedef struct packed {
      logic        func;
      logic [1:0]  op;
      logic [31:0] block_addr;
      logic [7:0]  block_count;
      logic [7:0]  miso_byte;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] mosi_byte;
      logic       card_selected;
      logic [7:0] read_data;
      logic       read_valid;
      logic       write_taken;
      logic       done_res;
      logic [1:0] status;
      logic       engine_busy;
   } rsp_type;

   typedef enum logic [4:0] {
      PH_IDLE, PH_PRE23, PH_PREMAIN, PH_FRAME23, PH_RESP23, PH_FRAMEMAIN,
      PH_RESPMAIN, PH_FRAME12, PH_RESP12, PH_RDTOKEN, PH_RDDATA, PH_RDCRC,
      PH_WRGAP, PH_WRDATA, PH_WRCRC, PH_WRRESP, PH_WRBUSY, PH_STOPBUSY
   } phase_type;

   localparam logic [1:0] CSR_CARD_TYPE = 2'd0;
   localparam logic [1:0] CSR_RESP_LIM  = 2'd1;
   localparam logic [1:0] CSR_BUSY_LIM  = 2'd2;

   localparam logic [1:0] CARD_SDHC = 2'd1;
   localparam logic [1:0] CARD_MMC  = 2'd2;

   localparam logic [1:0] OP_RD_SINGLE = 2'd0;
   localparam logic [1:0] OP_RD_MULTI  = 2'd1;
   localparam logic [1:0] OP_WR_SINGLE = 2'd2;
   localparam logic [1:0] OP_WR_MULTI  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_CMD_FAIL = 2'd1;
   localparam logic [1:0] ST_DATA_REJ = 2'd2;
   localparam logic [1:0] ST_BUSY_TO  = 2'd3;

   localparam logic [7:0] CMD_BASE    = 8'h40;
   localparam logic [7:0] TOK_START   = 8'hFE;
   localparam logic [7:0] TOK_MULTI   = 8'hFC;
   localparam logic [7:0] TOK_STOP    = 8'hFD;
   localparam logic [7:0] DRESP_MASK  = 8'h1F;
   localparam logic [7:0] DRESP_OK    = 8'h05;
   localparam logic [7:0] IDLE_BYTE   = 8'hFF;

   // Classified request that travels from front to back.
   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [31:0] card_address;
      logic [7:0]  blocks;
      logic        use_cmd23;
      logic [7:0]  miso_byte;
      logic [7:0]  write_data;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/sdspi_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_front
// Takes requests, resolves the card address and block count on starts.
// ----------------------------------------------------------------------------
module sdspi_front
   import sdspi_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire req_type req,
   output cmd_type      cmd,
   output logic [15:0]  resp_limit,
   output logic [15:0]  busy_limit
);
   logic [1:0]  card_type_ff;
   logic [15:0] resp_lim_ff, busy_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         card_type_ff <= 2'd0;
         resp_lim_ff  <= 16'd512;
         busy_lim_ff  <= 16'hFFFE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CARD_TYPE: card_type_ff <= csr_wdata[1:0];
            CSR_RESP_LIM:  resp_lim_ff  <= csr_wdata;
            CSR_BUSY_LIM:  busy_lim_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign resp_limit = resp_lim_ff;
   assign busy_limit = busy_lim_ff;

   always_comb begin
      cmd.start        = !req.func;
      cmd.op           = req.op;
      cmd.card_address = (card_type_ff == CARD_SDHC) ? req.block_addr
                         : {req.block_addr[22:0], 9'd0};
      cmd.blocks       = (req.op[0] && req.block_count != 8'd0) ? req.block_count : 8'd1;
      cmd.use_cmd23    = (req.op == OP_WR_MULTI) && (card_type_ff != CARD_MMC);
      cmd.miso_byte    = req.miso_byte;
      cmd.write_data   = req.write_data;
   end
endmodule
`default_nettype wire

// ===== rtl/sdspi_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_queue
// Two-entry queue between the front and the transfer sequencer.
// ----------------------------------------------------------------------------
module sdspi_queue
   import sdspi_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire cmd_type in_data,
   output logic         out_valid,
   input  wire logic    out_take,
   output cmd_type      out_data
);
   cmd_type    mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign pop       = out_valid && out_take;
   assign out_data  = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop)  rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (wptr_ff == rptr_ff))
      else $error("empty queue with pointer mismatch");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("push not counted");
endmodule
`default_nettype wire

// ===== rtl/sdspi_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_back
// Sequencer: unless stalled, one request per cycle into a response register.
// ----------------------------------------------------------------------------
module sdspi_back
   import sdspi_pkg::*;
#(
   parameter int BLOCK_BYTES = 512
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_take,
   input  wire cmd_type cmd,
   input  wire logic [15:0] resp_limit,
   input  wire logic [15:0] busy_limit,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int BW = $clog2(BLOCK_BYTES + 1);

   phase_type   phase_ff, phase_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  left_ff, left_in;
   logic [BW-1:0] bidx_ff, bidx_in;
   logic [2:0]  fidx_ff, fidx_in;
   logic [15:0] poll_ff, poll_in;
   logic        rv_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        fire;

   logic [7:0]  miso, fbyte, cmd_idx, crc, left_dec;
   logic [31:0] farg;
   logic        got, ready;

   assign cmd_take = cmd_valid && (!rv_ff || !rsp_stall);
   assign fire     = cmd_take;
   assign miso     = cmd.miso_byte;
   assign left_dec = left_ff - 8'd1;

   // Frame byte for the frame phase in progress.
   always_comb begin
      crc = IDLE_BYTE;
      case (phase_ff)
         PH_FRAME23: begin cmd_idx = 8'd23; farg = {24'd0, left_ff}; end
         PH_FRAME12: begin cmd_idx = 8'd12; farg = 32'd0; end
         default: begin
            case (op_ff)
               OP_RD_SINGLE: cmd_idx = 8'd17;
               OP_RD_MULTI:  cmd_idx = 8'd18;
               OP_WR_SINGLE: cmd_idx = 8'd24;
               default:      cmd_idx = 8'd25;
            endcase
            farg = addr_ff;
            if (!op_ff[0]) crc = 8'h01;
         end
      endcase
      case (fidx_ff)
         3'd0: fbyte = CMD_BASE | cmd_idx;
         3'd1: fbyte = farg[31:24];
         3'd2: fbyte = farg[23:16];
         3'd3: fbyte = farg[15:8];
         3'd4: fbyte = farg[7:0];
         default: fbyte = crc;
      endcase
   end

   // Next state
   always_comb begin
      phase_in = phase_ff; op_in = op_ff; addr_in = addr_ff; left_in = left_ff;
      bidx_in = bidx_ff; fidx_in = fidx_ff; poll_in = poll_ff;
      got   = (poll_ff != 16'd0) && (miso != IDLE_BYTE);
      ready = (poll_ff != 16'd0) &&
              ((op_ff == OP_WR_SINGLE) ? (miso != 8'd0) : (miso == IDLE_BYTE));
      if (cmd.start) begin
         if (phase_ff == PH_IDLE) begin
            op_in = cmd.op; addr_in = cmd.card_address; left_in = cmd.blocks;
            bidx_in = '0; fidx_in = 3'd0; poll_in = 16'd0;
            phase_in = cmd.use_cmd23 ? PH_PRE23 : PH_PREMAIN;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: ;
            PH_PRE23:   begin phase_in = PH_FRAME23;   fidx_in = 3'd0; end
            PH_PREMAIN: begin phase_in = PH_FRAMEMAIN; fidx_in = 3'd0; end
            PH_FRAME23, PH_FRAMEMAIN, PH_FRAME12: begin
               if (fidx_ff >= 3'd5) begin
                  poll_in = 16'd0;
                  case (phase_ff)
                     PH_FRAME23:   phase_in = PH_RESP23;
                     PH_FRAMEMAIN: phase_in = PH_RESPMAIN;
                     default:      phase_in = PH_RESP12;
                  endcase
               end else fidx_in = fidx_ff + 3'd1;
            end
            PH_RESP23, PH_RESPMAIN, PH_RESP12: begin
               if (!got && poll_ff < resp_limit) poll_in = poll_ff + 16'd1;
               else if (phase_ff == PH_RESP23) begin
                  phase_in = PH_FRAMEMAIN; fidx_in = 3'd0;
               end else if (phase_ff == PH_RESP12) phase_in = PH_IDLE;
               else if (!got || miso != 8'd0) phase_in = PH_IDLE;
               else if (!op_ff[1]) begin phase_in = PH_RDTOKEN; poll_in = 16'd1; end
               else begin phase_in = PH_WRGAP; fidx_in = 3'd1; end
            end
            PH_RDTOKEN: begin
               if (poll_ff != 16'd0 && miso == TOK_START) begin
                  phase_in = PH_RDDATA; bidx_in = '0;
               end else if (poll_ff >= busy_limit) phase_in = PH_IDLE;
               else poll_in = poll_ff + 16'd1;
            end
            PH_RDDATA: begin
               bidx_in = bidx_ff + BW'(1);
               if (bidx_in >= BW'(BLOCK_BYTES)) begin phase_in = PH_RDCRC; fidx_in = 3'd0; end
            end
            PH_RDCRC: begin
               if (fidx_ff == 3'd0) fidx_in = 3'd1;
               else begin
                  left_in = left_dec;
                  if (left_dec != 8'd0) begin phase_in = PH_RDTOKEN; poll_in = 16'd1; end
                  else if (op_ff == OP_RD_MULTI) begin phase_in = PH_FRAME12; fidx_in = 3'd0; end
                  else phase_in = PH_IDLE;
               end
            end
            PH_WRGAP: begin
               if (fidx_ff < ((op_ff == OP_WR_SINGLE) ? 3'd3 : 3'd2)) fidx_in = fidx_ff + 3'd1;
               else begin phase_in = PH_WRDATA; bidx_in = '0; end
            end
            PH_WRDATA: begin
               bidx_in = bidx_ff + BW'(1);
               if (bidx_in >= BW'(BLOCK_BYTES)) begin phase_in = PH_WRCRC; fidx_in = 3'd0; end
            end
            PH_WRCRC: begin
               if (fidx_ff < 3'd2) fidx_in = fidx_ff + 3'd1;
               else phase_in = PH_WRRESP;
            end
            PH_WRRESP: begin
               if ((miso & DRESP_MASK) != DRESP_OK) phase_in = PH_IDLE;
               else begin phase_in = PH_WRBUSY; poll_in = 16'd1; end
            end
            PH_WRBUSY: begin
               if (ready) begin
                  left_in = left_dec;
                  if (left_dec != 8'd0) begin phase_in = PH_WRDATA; bidx_in = '0; end
                  else if (op_ff == OP_WR_MULTI) begin phase_in = PH_STOPBUSY; poll_in = 16'd0; end
                  else phase_in = PH_IDLE;
               end else if (poll_ff >= busy_limit) phase_in = PH_IDLE;
               else poll_in = poll_ff + 16'd1;
            end
            PH_STOPBUSY: begin
               if (poll_ff != 16'd0 && miso == IDLE_BYTE) phase_in = PH_IDLE;
               else if (poll_ff >= busy_limit) phase_in = PH_IDLE;
               else poll_in = poll_ff + 16'd1;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // Outputs
   always_comb begin
      rsp_in = '0;
      rsp_in.mosi_byte = IDLE_BYTE;
      if (!cmd.start) begin
         case (phase_ff)
            PH_FRAME23, PH_FRAMEMAIN, PH_FRAME12: begin
               rsp_in.card_selected = 1'b1; rsp_in.mosi_byte = fbyte;
            end
            PH_RESP23, PH_RESPMAIN, PH_RESP12: begin
               if (!got && poll_ff < resp_limit) rsp_in.card_selected = 1'b1;
               else if (phase_ff == PH_RESP23) ;
               else if (phase_ff == PH_RESP12) rsp_in.done_res = 1'b1;
               else if (!got || miso != 8'd0) begin
                  rsp_in.done_res = 1'b1; rsp_in.status = ST_CMD_FAIL;
               end else rsp_in.card_selected = 1'b1;
            end
            PH_RDTOKEN: begin
               if (poll_ff != 16'd0 && miso == TOK_START) rsp_in.card_selected = 1'b1;
               else if (poll_ff >= busy_limit) begin
                  rsp_in.done_res = 1'b1; rsp_in.status = ST_CMD_FAIL;
               end else rsp_in.card_selected = 1'b1;
            end
            PH_RDDATA: begin
               rsp_in.card_selected = 1'b1; rsp_in.read_valid = 1'b1;
               rsp_in.read_data = miso;
            end
            PH_RDCRC: begin
               if (fidx_ff == 3'd0 || left_dec != 8'd0) rsp_in.card_selected = 1'b1;
               else if (op_ff != OP_RD_MULTI) rsp_in.done_res = 1'b1;
            end
            PH_WRGAP: begin
               rsp_in.card_selected = 1'b1;
               if (!(fidx_ff < ((op_ff == OP_WR_SINGLE) ? 3'd3 : 3'd2)))
                  rsp_in.mosi_byte = (op_ff == OP_WR_SINGLE) ? TOK_START : TOK_MULTI;
            end
            PH_WRDATA: begin
               rsp_in.card_selected = 1'b1; rsp_in.mosi_byte = cmd.write_data;
               rsp_in.write_taken = 1'b1;
            end
            PH_WRCRC: rsp_in.card_selected = 1'b1;
            PH_WRRESP: begin
               if ((miso & DRESP_MASK) != DRESP_OK) begin
                  rsp_in.done_res = 1'b1; rsp_in.status = ST_DATA_REJ;
               end else rsp_in.card_selected = 1'b1;
            end
            PH_WRBUSY: begin
               if (ready) begin
                  if (left_dec != 8'd0) begin
                     rsp_in.card_selected = 1'b1; rsp_in.mosi_byte = TOK_MULTI;
                  end else if (op_ff == OP_WR_MULTI) begin
                     rsp_in.card_selected = 1'b1; rsp_in.mosi_byte = TOK_STOP;
                  end else rsp_in.done_res = 1'b1;
               end else if (poll_ff >= busy_limit) begin
                  rsp_in.done_res = 1'b1; rsp_in.status = ST_BUSY_TO;
               end else rsp_in.card_selected = 1'b1;
            end
            PH_STOPBUSY: begin
               if (poll_ff != 16'd0 && miso == IDLE_BYTE) rsp_in.done_res = 1'b1;
               else if (poll_ff >= busy_limit) begin
                  rsp_in.done_res = 1'b1; rsp_in.status = ST_BUSY_TO;
               end else rsp_in.card_selected = 1'b1;
            end
            default: ;
         endcase
      end
      rsp_in.engine_busy = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; op_ff <= 2'd0; addr_ff <= '0; left_ff <= '0;
         bidx_ff <= '0; fidx_ff <= '0; poll_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff <= phase_in; op_ff <= op_in; addr_ff <= addr_in;
            left_ff <= left_in; bidx_ff <= bidx_in; fidx_ff <= fidx_in;
            poll_ff <= poll_in;
         end
         if (fire) rv_ff <= 1'b1;
         else if (!rsp_stall) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |-> !cmd_take)
      else $error("request taken over a held response");
   assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_in.status != ST_OK) |-> rsp_in.done_res)
      else $error("status without done");
   assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_in.done_res) |-> (phase_in == PH_IDLE && !rsp_in.card_selected))
      else $error("done while still running");
   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> (rv_ff && $stable(rsp_ff)))
      else $error("held response changed");
endmodule
`default_nettype wire

// ===== rtl/sd_spi_block_transfer_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sd_spi_block_transfer_engine_core
// SD card SPI-mode block read/write engine driven one byte slot per request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | req_type (start or byte slot)
//  rsp     | out       | rsp_valid/stall  | rsp_type (slot result)
//  csr     | in        | csr_we           | index + 16-bit data
// Every request yields one response. Front and back take one request per
// cycle each unless stalled, passing through the two-entry queue and the
// response register. Synchronous reset restores idle and register defaults.
// A stalled response holds and backs up the queue into req_stall.
module sd_spi_block_transfer_engine_core
   import sdspi_pkg::*;
#(
   parameter int BLOCK_BYTES = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   cmd_type     f_cmd, q_cmd;
   logic [15:0] resp_limit, busy_limit;
   logic        q_valid, q_take;

   sdspi_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req(req_data), .cmd(f_cmd), .resp_limit, .busy_limit
   );

   sdspi_queue u_queue (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall), .in_data(f_cmd),
      .out_valid(q_valid), .out_take(q_take), .out_data(q_cmd)
   );

   sdspi_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
      .clock, .reset, .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
      .resp_limit, .busy_limit, .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire
